### rtl/rrsa_pkg.sv
package rrsa_pkg;

    localparam int SERVERS_DEF    = 16;
    localparam int COUNT_BITS_DEF = 20;

    localparam int TIME_W     = 31;
    localparam int FINISH_W   = 32;
    localparam int NUM_SRV_W  = 5;
    localparam int SRV_IDX_W  = 4;

    localparam logic [NUM_SRV_W-1:0] NUM_SRV_RESET = 5'd16;

    localparam logic KIND_ASSIGN = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] arrival_time;
        logic [TIME_W-1:0] service_time;
        logic              end_of_batch;
    } t_req;

    typedef struct packed {
        logic                 kind;
        logic [SRV_IDX_W-1:0] server_index;
        logic                 dropped;
        logic                 is_last;
    } t_res;

    typedef struct packed {
        logic load_free;
        logic update;
        logic clear;
    } t_cell_ctl;

endpackage

### rtl/rrsa_cell.sv
module rrsa_cell #(
    parameter int SERVERS    = rrsa_pkg::SERVERS_DEF,
    parameter int COUNT_BITS = rrsa_pkg::COUNT_BITS_DEF,
    parameter int CELL_IDX   = 0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rrsa_pkg::t_cell_ctl            i_ctl,
    input  logic [rrsa_pkg::TIME_W-1:0]    i_arrival,
    input  logic [rrsa_pkg::FINISH_W-1:0]  i_finish,
    input  logic [$clog2(SERVERS)-1:0]     i_start,
    input  logic [$clog2(SERVERS+1)-1:0]   i_n_eff,
    input  logic [COUNT_BITS-1:0]          i_highest,
    input  logic                           i_seek_hi,
    input  logic                           i_seek_lo,
    input  logic                           i_any_hi,
    output logic                           o_seek_hi,
    output logic                           o_seek_lo,
    output logic                           o_grant,
    output logic [COUNT_BITS-1:0]          o_new_count,
    output logic                           o_match
);
    import rrsa_pkg::*;

    localparam int IB = $clog2(SERVERS);
    localparam int NB = $clog2(SERVERS+1);

    logic                  r_free;
    logic                  r_busy;
    logic [FINISH_W-1:0]   r_finish;
    logic [COUNT_BITS-1:0] r_count;

    logic                  w_in_use;
    logic                  w_ge;
    logic                  w_cand_hi;
    logic                  w_grant_hi;
    logic                  w_grant_lo;
    logic [COUNT_BITS-1:0] w_inc;

    assign w_in_use   = NB'(CELL_IDX) < i_n_eff;
    assign w_ge       = IB'(CELL_IDX) >= i_start;
    assign w_cand_hi  = r_free & w_ge;
    assign w_grant_hi = i_seek_hi & w_cand_hi;
    assign w_grant_lo = i_seek_lo & r_free;
    assign o_seek_hi  = i_seek_hi & ~w_cand_hi;
    assign o_seek_lo  = i_seek_lo & ~r_free;
    assign o_grant    = w_grant_hi | (w_grant_lo & ~i_any_hi);

    assign w_inc       = (r_count != '1) ? r_count + COUNT_BITS'(1) : r_count;
    assign o_new_count = o_grant ? w_inc : '0;
    assign o_match     = w_in_use & (r_count == i_highest);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_free   <= 1'b0;
            r_busy   <= 1'b0;
            r_finish <= '0;
            r_count  <= '0;
        end else begin
            if (i_ctl.load_free) begin
                r_free <= w_in_use & (~r_busy | (r_finish <= {1'b0, i_arrival}));
            end
            if (i_ctl.update && o_grant) begin
                r_busy   <= 1'b1;
                r_finish <= i_finish;
                r_count  <= w_inc;
            end
        end
    end

endmodule

### rtl/round_robin_server_assigner.sv
// Without end_of_batch, the accepting edge enters S_ASSIGN, which registers the assignment result.
// A new item is taken only while busy is low; the free flags load at the accepting edge and the
// cell chain is searched in S_ASSIGN; end_of_batch adds one S_REPORT step per server in use, then S_FLUSH.
// After a num_servers write, busy stays high while the position wraps back into range.
// Reset: synchronous, active low; clears all server state, position 0, num_servers 16.
// The receiver cannot stall: each result is on the ports for exactly one cycle.
module round_robin_server_assigner #(
    parameter int SERVERS    = rrsa_pkg::SERVERS_DEF,
    parameter int COUNT_BITS = rrsa_pkg::COUNT_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  rrsa_pkg::t_req                     i_req,
    output logic                               o_result_valid,
    output rrsa_pkg::t_res                     o_res,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rrsa_pkg::NUM_SRV_W-1:0]     i_cfg_data
);
    import rrsa_pkg::*;

    localparam int IB = $clog2(SERVERS);
    localparam int NB = $clog2(SERVERS+1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_ASSIGN = 4'b0010,
        S_REPORT = 4'b0100,
        S_FLUSH  = 4'b1000
    } t_state;

    t_state                r_state,   n_state;
    logic [NUM_SRV_W-1:0]  r_cfg_n;
    logic [IB-1:0]         r_pos,     n_pos;
    logic [COUNT_BITS-1:0] r_highest, n_highest;
    logic [FINISH_W-1:0]   r_finish,  n_finish;
    logic                  r_eob,     n_eob;
    logic [IB-1:0]         r_rep,     n_rep;
    t_res                  r_pend,    n_pend;
    logic                  r_out_valid, n_out_valid;
    t_res                  r_out,     n_out;

    logic [NB-1:0]         w_n_eff;
    logic                  w_pos_oor;
    logic [NB-1:0]         w_pos_inc;
    logic                  w_accept;
    t_cell_ctl             w_ctl;
    logic [SERVERS:0]      w_seek_hi;
    logic [SERVERS:0]      w_seek_lo;
    logic [SERVERS-1:0]    w_grant;
    logic [SERVERS-1:0]    w_match;
    logic [COUNT_BITS-1:0] w_cnt_arr [SERVERS];
    logic                  w_any_hi;
    logic                  w_found;
    logic [IB-1:0]         w_chosen;
    logic [COUNT_BITS-1:0] w_new_count;
    t_res                  w_assign_res;

    always_comb begin
        if (r_cfg_n == '0) begin
            w_n_eff = NB'(1);
        end else if (int'(r_cfg_n) > SERVERS) begin
            w_n_eff = NB'(SERVERS);
        end else begin
            w_n_eff = NB'(r_cfg_n);
        end
    end

    assign w_pos_oor   = NB'(r_pos) >= w_n_eff;
    assign w_pos_inc   = NB'(r_pos) + NB'(1);
    assign busy        = (r_state != S_IDLE) | w_pos_oor;
    assign w_accept    = start & ~busy;
    assign o_cfg_ready = (r_state == S_IDLE);

    assign w_ctl.load_free = w_accept;
    assign w_ctl.update    = (r_state == S_ASSIGN);
    assign w_ctl.clear     = (r_state == S_FLUSH);

    assign w_seek_hi[0] = 1'b1;
    assign w_seek_lo[0] = 1'b1;
    assign w_any_hi     = ~w_seek_hi[SERVERS];
    assign w_found      = ~w_seek_lo[SERVERS];

    for (genvar g = 0; g < SERVERS; g++) begin : g_cell
        rrsa_cell #(
            .SERVERS    (SERVERS),
            .COUNT_BITS (COUNT_BITS),
            .CELL_IDX   (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_arrival   (i_req.arrival_time),
            .i_finish    (r_finish),
            .i_start     (r_pos),
            .i_n_eff     (w_n_eff),
            .i_highest   (r_highest),
            .i_seek_hi   (w_seek_hi[g]),
            .i_seek_lo   (w_seek_lo[g]),
            .i_any_hi    (w_any_hi),
            .o_seek_hi   (w_seek_hi[g+1]),
            .o_seek_lo   (w_seek_lo[g+1]),
            .o_grant     (w_grant[g]),
            .o_new_count (w_cnt_arr[g]),
            .o_match     (w_match[g])
        );
    end

    always_comb begin
        w_chosen    = '0;
        w_new_count = '0;
        for (int i = 0; i < SERVERS; i++) begin
            w_chosen    = w_chosen | (w_grant[i] ? IB'(i) : '0);
            w_new_count = w_new_count | w_cnt_arr[i];
        end
    end

    always_comb begin
        w_assign_res.kind         = KIND_ASSIGN;
        w_assign_res.server_index = w_found ? SRV_IDX_W'(w_chosen) : '0;
        w_assign_res.dropped      = ~w_found;
        w_assign_res.is_last      = ~r_eob;
    end

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_highest   = r_highest;
        n_finish    = r_finish;
        n_eob       = r_eob;
        n_rep       = r_rep;
        n_pend      = r_pend;
        n_out_valid = 1'b0;
        n_out       = r_out;
        case (r_state)
            S_IDLE: begin
                if (w_pos_oor) begin
                    n_pos = IB'(NB'(r_pos) - w_n_eff);
                end else if (start) begin
                    n_finish = {1'b0, i_req.arrival_time} + {1'b0, i_req.service_time};
                    n_eob    = i_req.end_of_batch;
                    n_state  = S_ASSIGN;
                end
            end
            S_ASSIGN: begin
                if (w_found && (w_new_count > r_highest)) begin
                    n_highest = w_new_count;
                end
                n_pos = (w_pos_inc == w_n_eff) ? '0 : IB'(w_pos_inc);
                if (r_eob) begin
                    n_pend  = w_assign_res;
                    n_rep   = '0;
                    n_state = S_REPORT;
                end else begin
                    n_out_valid = 1'b1;
                    n_out       = w_assign_res;
                    n_state     = S_IDLE;
                end
            end
            S_REPORT: begin
                if (w_match[r_rep]) begin
                    n_out_valid         = 1'b1;
                    n_out               = r_pend;
                    n_pend.kind         = KIND_REPORT;
                    n_pend.server_index = SRV_IDX_W'(r_rep);
                    n_pend.dropped      = 1'b0;
                    n_pend.is_last      = 1'b0;
                end
                if (NB'(r_rep) == w_n_eff - NB'(1)) begin
                    n_state = S_FLUSH;
                end else begin
                    n_rep = r_rep + IB'(1);
                end
            end
            S_FLUSH: begin
                n_out_valid   = 1'b1;
                n_out         = r_pend;
                n_out.is_last = 1'b1;
                n_highest     = '0;
                n_pos         = '0;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_n     <= NUM_SRV_RESET;
            r_pos       <= '0;
            r_highest   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_highest   <= n_highest;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg_n <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_finish <= n_finish;
        r_eob    <= n_eob;
        r_rep    <= n_rep;
        r_pend   <= n_pend;
        r_out    <= n_out;
    end

    assign o_result_valid = r_out_valid;
    assign o_res          = r_out;

    a_one_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ASSIGN) |-> $onehot0(w_grant))
        else $error("more than one server granted");

    a_accept_assign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_ASSIGN))
        else $error("accepted item not assigned");

    a_assign_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_ASSIGN) && !r_eob) |=>
        (o_result_valid && (o_res.kind == KIND_ASSIGN) && o_res.is_last))
        else $error("assignment result missing");

    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |=> (o_result_valid && o_res.is_last && (r_state == S_IDLE)))
        else $error("batch report not closed");

endmodule
